### rtl/frf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Free text rectangle finder package
// Shared types, field widths and layout constants of the rectangle finder.
// ---------------------------------------------------------------------------
package frf_pkg;

	// Width of every coordinate field on the ports.
	localparam int FIELD_BITS = 15;
	// Width of the column count register.
	localparam int NCOL_BITS = 5;
	// Width of the configuration register index.
	localparam int CFG_IDX_BITS = 3;
	// Signed width of the column numerator; its magnitude stays below 2**20.
	localparam int NUM_BITS = 22;
	// Magnitude width handled by the column divider.
	localparam int DIV_BITS = 20;
	// Width of the gutter product (column count minus one, times gutter).
	localparam int PROD_BITS = 20;

	// Layout constants.
	localparam int GRAPHIC_BORDER = 80;
	localparam int MIN_SPAN = 144;
	localparam int MIN_HEIGHT = 48;

	// Item operation codes.
	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_QUERY  = 2'd2
	} mode_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_PAGE_WIDTH    = 3'd0,
		REG_LEFT_MARGIN   = 3'd1,
		REG_RIGHT_MARGIN  = 3'd2,
		REG_NUM_COLUMNS   = 3'd3,
		REG_COLUMN_GUTTER = 3'd4,
		REG_PAGE_HEIGHT   = 3'd5,
		REG_BOTTOM_MARGIN = 3'd6
	} cfg_reg_t;

	// One stored obstacle, kept as the raw 15-bit fields of its append beat.
	typedef struct packed {
		logic [FIELD_BITS-1:0] left;
		logic [FIELD_BITS-1:0] top;
		logic [FIELD_BITS-1:0] width;
		logic [FIELD_BITS-1:0] height;
		logic                  see_through;
	} obst_t;

endpackage

### rtl/frf_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Obstacle table
// Single-port-write, single-port-read memory of obstacles with registered
// read data.
// ---------------------------------------------------------------------------
module frf_table #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  frf_pkg::obst_t wdata,
	input  logic [AW-1:0] raddr,
	output frf_pkg::obst_t rdata
);
	import frf_pkg::*;

	obst_t mem [DEPTH];
	obst_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/frf_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Column divider
// Restoring divider that retires one quotient bit per cycle.
// ---------------------------------------------------------------------------
module frf_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [frf_pkg::DIV_BITS-1:0]     dividend,
	input  logic [frf_pkg::NCOL_BITS-1:0]    divisor,
	output logic                             done,
	output logic [frf_pkg::DIV_BITS-1:0]     quotient
);
	import frf_pkg::*;

	localparam int STEP_BITS = $clog2(DIV_BITS + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_BITS-1:0] step_q;
	logic [DIV_BITS-1:0]  quo_q;
	logic [NCOL_BITS-1:0] rem_q;
	logic [NCOL_BITS-1:0] div_q;
	logic [NCOL_BITS:0]   trial;
	logic                 take;

	// The partial remainder stays below the divisor, so one more bit is enough.
	assign trial = {rem_q, quo_q[DIV_BITS-1]};
	assign take  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_BITS'(DIV_BITS);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_BITS-2:0], take};
			rem_q <= take ? NCOL_BITS'(trial - {1'b0, div_q}) : trial[NCOL_BITS-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/free_text_rect_finder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Free text rectangle finder
// Keeps a table of page obstacles and answers free-rectangle queries for
// text flow, using one column divider and a single obstacle evaluation unit.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Beat contents
//   in        input      in_valid / in_stall  mode, obstacle fields, start point
//   out       output     out_valid / out_stall found, rectangle, blocked
//   cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A clear, an append or an unused mode yields no beat and leaves the block idle.
// A query runs the bit-serial column divider, then two passes over the table,
// one entry per cycle through its single read port; a span that gets too
// narrow in the first pass ends the query without the second.
// Reset empties the table at once (the entry count goes to zero); the table
// memory itself is never swept.
// in_stall is high while a query is at work; a finished result waits in the
// output register, and a later query only stalls at its end if it is still held.
// ---------------------------------------------------------------------------
module free_text_rect_finder #(
	parameter int MAX_OBSTACLES = 64,
	parameter int COORD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Item channel.
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          mode,
	input  logic [frf_pkg::FIELD_BITS-1:0]      obstacle_left,
	input  logic [frf_pkg::FIELD_BITS-1:0]      obstacle_top,
	input  logic [frf_pkg::FIELD_BITS-1:0]      obstacle_width,
	input  logic [frf_pkg::FIELD_BITS-1:0]      obstacle_height,
	input  logic                                see_through,
	input  logic [frf_pkg::FIELD_BITS-1:0]      start_left,
	input  logic [frf_pkg::FIELD_BITS-1:0]      start_top,
	// Result channel.
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                found,
	output logic [frf_pkg::FIELD_BITS-1:0]      rect_left,
	output logic [frf_pkg::FIELD_BITS-1:0]      rect_top,
	output logic [frf_pkg::FIELD_BITS-1:0]      rect_width,
	output logic [frf_pkg::FIELD_BITS-1:0]      rect_height,
	output logic                                blocked,
	// Configuration write channel.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [frf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [frf_pkg::FIELD_BITS-1:0]      cfg_data
);
	import frf_pkg::*;

	// Table addressing. The count needs one more value than the address.
	localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
	localparam int CNTW = $clog2(MAX_OBSTACLES + 1);
	localparam int CB = COORD_BITS;
	// Comparison width: exact for sums of two coordinates, for the 21-bit
	// signed quotient and for the unsigned page height.
	localparam int XW = ((CB > 21) ? CB : 21) + 2;

	localparam logic signed [XW-1:0] K_SPAN   = XW'(MIN_SPAN);
	localparam logic signed [XW-1:0] K_HEIGHT = XW'(MIN_HEIGHT);
	localparam logic signed [CB-1:0] K_BORDER = CB'(GRAPHIC_BORDER);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_DIV,
		S_PASS1,
		S_PASS2,
		S_DONE
	} state_t;

	// Wraps a raw 15-bit field into a signed coordinate of CB bits.
	function automatic logic signed [CB-1:0] wrap15(input logic [FIELD_BITS-1:0] v);
		logic [XW-1:0] t;
		t = XW'(v);
		return t[CB-1:0];
	endfunction

	// -----------------------------------------------------------------------
	// Configuration registers. Writes are to be issued only while idle (unchecked).
	// -----------------------------------------------------------------------
	logic [FIELD_BITS-1:0] page_width_q;
	logic [FIELD_BITS-1:0] left_margin_q;
	logic [FIELD_BITS-1:0] right_margin_q;
	logic [NCOL_BITS-1:0]  num_columns_q;
	logic [FIELD_BITS-1:0] column_gutter_q;
	logic [FIELD_BITS-1:0] page_height_q;
	logic [FIELD_BITS-1:0] bottom_margin_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_width_q    <= '0;
			left_margin_q   <= '0;
			right_margin_q  <= '0;
			num_columns_q   <= NCOL_BITS'(1);
			column_gutter_q <= '0;
			page_height_q   <= '0;
			bottom_margin_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PAGE_WIDTH:    page_width_q    <= cfg_data;
				REG_LEFT_MARGIN:   left_margin_q   <= cfg_data;
				REG_RIGHT_MARGIN:  right_margin_q  <= cfg_data;
				REG_NUM_COLUMNS:   num_columns_q   <= cfg_data[NCOL_BITS-1:0];
				REG_COLUMN_GUTTER: column_gutter_q <= cfg_data;
				REG_PAGE_HEIGHT:   page_height_q   <= cfg_data;
				REG_BOTTOM_MARGIN: bottom_margin_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// -----------------------------------------------------------------------
	// Control and datapath registers.
	// -----------------------------------------------------------------------
	state_t                 state_q;
	logic [CNTW-1:0]        count_q;
	logic [CNTW-1:0]        addr_q;
	logic                   pend_s1;
	logic signed [CB-1:0]   px_q;
	logic signed [CB-1:0]   py_q;
	logic signed [CB-1:0]   pw_q;
	logic signed [CB-1:0]   lim_q;
	logic                   blk_q;
	logic                   fail_q;
	logic                   neg_q;
	logic                   out_valid_q;
	logic                   found_q;
	logic [FIELD_BITS-1:0]  rect_left_q;
	logic [FIELD_BITS-1:0]  rect_top_q;
	logic [FIELD_BITS-1:0]  rect_width_q;
	logic [FIELD_BITS-1:0]  rect_height_q;
	logic                   blocked_q;

	logic in_accept;
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;

	// -----------------------------------------------------------------------
	// Obstacle table. Appends write at the current count; the scans read one
	// entry a cycle, and the entry is evaluated the cycle after its address.
	// -----------------------------------------------------------------------
	logic   tbl_we;
	obst_t  tbl_wdata;
	obst_t  ent;
	logic   room;

	assign room   = count_q < CNTW'(MAX_OBSTACLES);
	assign tbl_we = in_accept && (mode == MODE_APPEND) && room;
	assign tbl_wdata = '{left: obstacle_left, top: obstacle_top, width: obstacle_width,
		height: obstacle_height, see_through: see_through};

	frf_table #(
		.DEPTH(MAX_OBSTACLES),
		.AW(AW)
	) u_table (
		.clk(clk),
		.we(tbl_we),
		.waddr(count_q[AW-1:0]),
		.wdata(tbl_wdata),
		.raddr(addr_q[AW-1:0]),
		.rdata(ent)
	);

	// -----------------------------------------------------------------------
	// Column pitch. The numerator is page width less both margins and the
	// inner gutters; its magnitude goes through the divider and the sign is
	// put back afterwards, which truncates toward zero. The starting span is
	// the pitch minus one gutter, which modulo the coordinate width is simply
	// the wrapped quotient.
	// -----------------------------------------------------------------------
	logic [NCOL_BITS-1:0]      ncol_eff;
	logic [PROD_BITS-1:0]      gut_prod;
	logic [NUM_BITS-1:0]       num_u;
	logic [NUM_BITS-1:0]       num_abs;
	logic [NUM_BITS-1:0]       lim_diff;
	logic signed [XW-1:0]      lim_x;
	logic                      div_start;
	logic                      div_done;
	logic [DIV_BITS-1:0]       quo;
	logic signed [DIV_BITS:0]  quo_s;
	logic signed [XW-1:0]      quo_x;

	assign ncol_eff = (num_columns_q == '0) ? NCOL_BITS'(1) : num_columns_q;
	assign gut_prod = PROD_BITS'(ncol_eff - 1'b1) * PROD_BITS'(column_gutter_q);
	assign num_u    = NUM_BITS'(page_width_q) - NUM_BITS'(right_margin_q)
		- NUM_BITS'(left_margin_q) - NUM_BITS'(gut_prod);
	assign num_abs  = num_u[NUM_BITS-1] ? (~num_u + 1'b1) : num_u;
	assign lim_diff = NUM_BITS'(page_height_q) - NUM_BITS'(bottom_margin_q);
	assign lim_x    = XW'($signed(lim_diff));
	assign div_start = (state_q == S_PREP);

	frf_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(num_abs[DIV_BITS-1:0]),
		.divisor(ncol_eff),
		.done(div_done),
		.quotient(quo)
	);

	assign quo_s = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
	assign quo_x = XW'(quo_s);

	// -----------------------------------------------------------------------
	// Obstacle evaluation unit, shared by both scans.
	// -----------------------------------------------------------------------
	logic signed [CB-1:0] ox, oy, ow, oh;
	logic signed [XW-1:0] e_ox, e_oy, e_ow, e_oh, e_px, e_py, e_pw, e_lim;
	logic signed [XW-1:0] e_bot;
	logic                 ovl, on_row, below, narrow_right;
	logic signed [CB-1:0] new_px, pw_right, pw_left, px_n, pw_n;
	logic                 hit1, hit2, fail1;

	always_comb begin
		ox = wrap15(ent.left);
		oy = wrap15(ent.top);
		ow = wrap15(ent.width);
		oh = wrap15(ent.height);
		e_ox  = XW'(ox);
		e_oy  = XW'(oy);
		e_ow  = XW'(ow);
		e_oh  = XW'(oh);
		e_px  = XW'(px_q);
		e_py  = XW'(py_q);
		e_pw  = XW'(pw_q);
		e_lim = XW'(lim_q);
		e_bot = e_oy + e_oh;

		// Horizontal overlap of the obstacle with the current span.
		ovl = (e_ox <= e_px + e_pw) && ((e_ox >= e_px) || (e_ox + e_ow >= e_px));
		// The obstacle covers the start row.
		on_row = (e_oy <= e_py) && (e_bot > e_py);
		// The obstacle starts strictly between the start row and the limit.
		below = (e_oy > e_py) && (e_oy < e_lim);

		// An obstacle well to the right cuts the span on its right side;
		// otherwise the span restarts past the obstacle's right edge.
		narrow_right = e_ox > e_px + K_SPAN;
		pw_right = ox - px_q - K_BORDER;
		new_px   = ox + ow + K_BORDER;
		pw_left  = pw_q - new_px + px_q;
		px_n = narrow_right ? px_q : new_px;
		pw_n = narrow_right ? pw_right : pw_left;
		fail1 = XW'(pw_n) < K_SPAN;

		hit1 = pend_s1 && !ent.see_through && ovl && on_row;
		hit2 = pend_s1 && !ent.see_through && ovl && below;
	end

	// -----------------------------------------------------------------------
	// Result formation: the height runs from the start row to the limit.
	// -----------------------------------------------------------------------
	logic signed [CB-1:0] ph;
	logic signed [XW-1:0] e_ph;
	logic                 res_ok;
	logic                 out_free;
	logic                 scan_done;

	assign ph   = lim_q - py_q;
	assign e_ph = XW'(ph);
	assign res_ok = !fail_q && (e_ph >= K_HEIGHT) && (e_ph <= $signed(XW'(page_height_q)));
	assign out_free  = !out_valid_q || !out_stall;
	assign scan_done = !pend_s1 && (addr_q == count_q);

	// -----------------------------------------------------------------------
	// Sequencer.
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			addr_q      <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						case (mode)
							MODE_CLEAR: count_q <= '0;
							MODE_APPEND: begin
								if (room) begin
									count_q <= count_q + 1'b1;
								end
							end
							MODE_QUERY: begin
								px_q    <= wrap15(start_left);
								py_q    <= wrap15(start_top);
								state_q <= S_PREP;
							end
							default: ;
						endcase
					end
				end
				S_PREP: begin
					neg_q   <= num_u[NUM_BITS-1];
					lim_q   <= lim_x[CB-1:0];
					blk_q   <= 1'b1;
					fail_q  <= 1'b0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						pw_q    <= quo_x[CB-1:0];
						addr_q  <= '0;
						pend_s1 <= 1'b0;
						state_q <= S_PASS1;
					end
				end
				S_PASS1: begin
					if (hit1) begin
						blk_q <= 1'b0;
						if (e_bot < e_lim) begin
							lim_q <= e_bot[CB-1:0];
						end
						px_q <= px_n;
						pw_q <= pw_n;
					end
					if (hit1 && fail1) begin
						fail_q  <= 1'b1;
						pend_s1 <= 1'b0;
						state_q <= S_DONE;
					end else if (scan_done) begin
						addr_q  <= '0;
						state_q <= S_PASS2;
					end else begin
						pend_s1 <= (addr_q != count_q);
						if (addr_q != count_q) begin
							addr_q <= addr_q + 1'b1;
						end
					end
				end
				S_PASS2: begin
					if (hit2) begin
						lim_q <= oy;
						blk_q <= 1'b1;
					end
					if (scan_done) begin
						state_q <= S_DONE;
					end else begin
						pend_s1 <= (addr_q != count_q);
						if (addr_q != count_q) begin
							addr_q <= addr_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						found_q       <= res_ok;
						rect_left_q   <= res_ok ? e_px[FIELD_BITS-1:0] : '0;
						rect_top_q    <= res_ok ? e_py[FIELD_BITS-1:0] : '0;
						rect_width_q  <= res_ok ? e_pw[FIELD_BITS-1:0] : '0;
						rect_height_q <= res_ok ? e_ph[FIELD_BITS-1:0] : '0;
						blocked_q     <= res_ok && blk_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign rect_left   = rect_left_q;
	assign rect_top    = rect_top_q;
	assign rect_width  = rect_width_q;
	assign rect_height = rect_height_q;
	assign blocked     = blocked_q;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Free text rectangle finder testbench
// Drives clear, append and query beats into the rectangle finder under random
// idling on both channels, predicts every query answer from its own copy of
// the obstacle table and page geometry, and compares each result beat field
// by field. Geometry registers are reprogrammed between phases, extremes
// included.
// ---------------------------------------------------------------------------
module testbench;
	import frf_pkg::*;

	localparam int MAX_OBST = 64;
	localparam int COORD_BITS = 16;
	// Settling wait after the last beat; a clear or an append lands well within it.
	localparam int SETTLE_CYCLES = 8;
	// Drain wait at the end, longer than the longest query.
	localparam int DRAIN_CYCLES = 200;
	// Cycles without any handshake before the run is declared hung. The long
	// receiver hold-off below is much shorter than this limit.
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int NUM_LAYOUT_REGS = REG_BOTTOM_MARGIN + 1;
	// Mode code that the block decodes to nothing.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef enum {LAYOUT_TYPICAL, LAYOUT_WILD, LAYOUT_ZERO, LAYOUT_MAX} layout_kind_t;
	typedef int unsigned layout_regs_t [NUM_LAYOUT_REGS];

	// One beat on the item channel.
	typedef struct packed {
		logic [1:0]            mode;
		obst_t                 obst;
		logic [FIELD_BITS-1:0] start_left;
		logic [FIELD_BITS-1:0] start_top;
	} layout_beat_t;

	// One beat on the result channel.
	typedef struct packed {
		logic                  found;
		logic [FIELD_BITS-1:0] left;
		logic [FIELD_BITS-1:0] top;
		logic [FIELD_BITS-1:0] width;
		logic [FIELD_BITS-1:0] height;
		logic                  blocked;
	} free_rect_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [1:0]              mode;
	logic [FIELD_BITS-1:0]   obstacle_left;
	logic [FIELD_BITS-1:0]   obstacle_top;
	logic [FIELD_BITS-1:0]   obstacle_width;
	logic [FIELD_BITS-1:0]   obstacle_height;
	logic                    see_through;
	logic [FIELD_BITS-1:0]   start_left;
	logic [FIELD_BITS-1:0]   start_top;
	logic                    out_valid;
	logic                    out_stall;
	logic                    found;
	logic [FIELD_BITS-1:0]   rect_left;
	logic [FIELD_BITS-1:0]   rect_top;
	logic [FIELD_BITS-1:0]   rect_width;
	logic [FIELD_BITS-1:0]   rect_height;
	logic                    blocked;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [FIELD_BITS-1:0]   cfg_data;

	// Shadow of the block's state: the obstacle table and the page geometry,
	// both at their reset values until written.
	obst_t                 obst_table [MAX_OBST];
	int                    obst_count = 0;
	logic [FIELD_BITS-1:0] lay_page_w = '0;
	logic [FIELD_BITS-1:0] lay_left_m = '0;
	logic [FIELD_BITS-1:0] lay_right_m = '0;
	logic [NCOL_BITS-1:0]  lay_cols = NCOL_BITS'(1);
	logic [FIELD_BITS-1:0] lay_gutter = '0;
	logic [FIELD_BITS-1:0] lay_page_h = '0;
	logic [FIELD_BITS-1:0] lay_bottom_m = '0;

	// Answers still owed by the block, oldest first.
	free_rect_t expected_rects [$];
	int         fail_count = 0;
	int         beats_sent = 0;

	// Idling controls shared with the receiver process.
	bit in_idle_on = 1'b1;
	bit out_idle_on = 1'b1;
	int hold_off_len = 0;

	free_text_rect_finder #(
		.MAX_OBSTACLES(MAX_OBST),
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.obstacle_left(obstacle_left),
		.obstacle_top(obstacle_top),
		.obstacle_width(obstacle_width),
		.obstacle_height(obstacle_height),
		.see_through(see_through),
		.start_left(start_left),
		.start_top(start_top),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.rect_left(rect_left),
		.rect_top(rect_top),
		.rect_width(rect_width),
		.rect_height(rect_height),
		.blocked(blocked),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Coordinates live in a COORD_BITS-wide two's complement datapath.
	function automatic longint coord_wrap(input longint v);
		longint m;
		m = longint'(1) <<< COORD_BITS;
		v = v & (m - 1);
		if (v >= (m >>> 1))
			v = v - m;
		return v;
	endfunction

	// Horizontal overlap test of the layout engine. It is deliberately lopsided:
	// an obstacle starting inside the span always counts, one starting to the
	// left counts only if its right edge reaches the span.
	function automatic bit spans_touch(input longint x1, input longint w1,
	                                   input longint x2, input longint w2);
		return (x1 <= x2 + w2) && ((x1 >= x2) || (x1 + w1 >= x2));
	endfunction

	// Works out the free rectangle for a start point from the shadow table and
	// geometry. A rectangle that is too narrow or has an unusable height comes
	// back as an all-zero beat.
	function automatic free_rect_t find_free_rect(input logic [FIELD_BITS-1:0] sx,
	                                              input logic [FIELD_BITS-1:0] sy);
		free_rect_t res;
		longint     ncol, gutter, numer, pitch, x, y, span, floor_y, h;
		longint     ox, oy, ow, oh, t;
		logic       bounded;
		res     = '0;
		// A column count of zero is read as a single column.
		ncol    = (lay_cols == '0) ? longint'(1) : longint'(lay_cols);
		gutter  = longint'(lay_gutter);
		numer   = longint'(lay_page_w) - longint'(lay_right_m) - longint'(lay_left_m)
		        - (ncol - 1) * gutter;
		pitch   = coord_wrap(numer / ncol + gutter);
		x       = coord_wrap(longint'(sx));
		y       = coord_wrap(longint'(sy));
		span    = coord_wrap(pitch - coord_wrap(gutter));
		floor_y = coord_wrap(longint'(lay_page_h) - longint'(lay_bottom_m));
		bounded = 1'b1;

		// First pass: opaque obstacles that cover the start row squeeze the span
		// from the right or push its left edge past them.
		for (int i = 0; i < obst_count; i++) begin
			if (obst_table[i].see_through)
				continue;
			ox = coord_wrap(longint'(obst_table[i].left));
			oy = coord_wrap(longint'(obst_table[i].top));
			ow = coord_wrap(longint'(obst_table[i].width));
			oh = coord_wrap(longint'(obst_table[i].height));
			if (!spans_touch(ox, ow, x, span))
				continue;
			if (oy <= y && oy + oh > y) begin
				bounded = 1'b0;
				t = oy + oh;
				if (t < floor_y)
					floor_y = coord_wrap(t);
				if (ox > x + MIN_SPAN) begin
					span = coord_wrap(ox - x - GRAPHIC_BORDER);
				end else begin
					t = x;
					x = coord_wrap(ox + ow + GRAPHIC_BORDER);
					span = coord_wrap(span - (x - t));
				end
				if (span < MIN_SPAN)
					return res;
			end
		end

		// Second pass: the nearest opaque obstacle below the start row, within
		// the final span, caps the height.
		for (int i = 0; i < obst_count; i++) begin
			if (obst_table[i].see_through)
				continue;
			ox = coord_wrap(longint'(obst_table[i].left));
			oy = coord_wrap(longint'(obst_table[i].top));
			ow = coord_wrap(longint'(obst_table[i].width));
			if (spans_touch(ox, ow, x, span) && oy > y && oy < floor_y) begin
				floor_y = oy;
				bounded = 1'b1;
			end
		end

		h = coord_wrap(floor_y - y);
		if (h < MIN_HEIGHT || h > longint'(lay_page_h))
			return res;
		res.found   = 1'b1;
		res.left    = x[FIELD_BITS-1:0];
		res.top     = y[FIELD_BITS-1:0];
		res.width   = span[FIELD_BITS-1:0];
		res.height  = h[FIELD_BITS-1:0];
		res.blocked = bounded;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Channel drivers
	// ------------------------------------------------------------------

	// Offers one item beat, possibly after a random gap, and holds it until the
	// block takes it. The shadow state moves at the accepting edge, in order.
	task automatic send_beat(input layout_beat_t b);
		if (in_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid        <= 1'b1;
		mode            <= b.mode;
		obstacle_left   <= b.obst.left;
		obstacle_top    <= b.obst.top;
		obstacle_width  <= b.obst.width;
		obstacle_height <= b.obst.height;
		see_through     <= b.obst.see_through;
		start_left      <= b.start_left;
		start_top       <= b.start_top;
		do @(posedge clk); while (in_stall);
		beats_sent++;
		case (b.mode)
			MODE_CLEAR: begin
				obst_count = 0;
			end
			MODE_APPEND: begin
				// A full table drops further appends.
				if (obst_count < MAX_OBST) begin
					obst_table[obst_count] = b.obst;
					obst_count++;
				end
			end
			MODE_QUERY: begin
				expected_rects.push_back(find_free_rect(b.start_left, b.start_top));
			end
			default: ;
		endcase
	endtask

	// Lowers valid, lets every owed answer arrive, then gives a clear or append
	// still in flight time to land. After this the block is idle.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_rects.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes every geometry register in index order, keeping valid high across
	// back-to-back writes. Only called while the block is idle.
	task automatic load_layout(input layout_regs_t regs);
		for (int r = 0; r < NUM_LAYOUT_REGS; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_reg_t'(r);
			cfg_data  <= regs[r][FIELD_BITS-1:0];
			do @(posedge clk); while (!cfg_ready);
			case (cfg_reg_t'(r))
				REG_PAGE_WIDTH:    lay_page_w   = regs[r][FIELD_BITS-1:0];
				REG_LEFT_MARGIN:   lay_left_m   = regs[r][FIELD_BITS-1:0];
				REG_RIGHT_MARGIN:  lay_right_m  = regs[r][FIELD_BITS-1:0];
				REG_NUM_COLUMNS:   lay_cols     = regs[r][NCOL_BITS-1:0];
				REG_COLUMN_GUTTER: lay_gutter   = regs[r][FIELD_BITS-1:0];
				REG_PAGE_HEIGHT:   lay_page_h   = regs[r][FIELD_BITS-1:0];
				REG_BOTTOM_MARGIN: lay_bottom_m = regs[r][FIELD_BITS-1:0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic [FIELD_BITS-1:0] coord15(input int v);
		return v[FIELD_BITS-1:0];
	endfunction

	// Every field random over its full range; callers override what matters.
	function automatic layout_beat_t random_beat(input logic [1:0] m);
		layout_beat_t b;
		b.mode             = m;
		b.obst.left        = coord15($urandom_range(0, 32767));
		b.obst.top         = coord15($urandom_range(0, 32767));
		b.obst.width       = coord15($urandom_range(0, 32767));
		b.obst.height      = coord15($urandom_range(0, 32767));
		b.obst.see_through = $urandom_range(0, 1);
		b.start_left       = coord15($urandom_range(0, 32767));
		b.start_top        = coord15($urandom_range(0, 32767));
		return b;
	endfunction

	task automatic append_obst(input int l, input int t, input int w, input int h,
	                           input logic clear_mark);
		layout_beat_t b;
		b = random_beat(MODE_APPEND);
		b.obst.left        = coord15(l);
		b.obst.top         = coord15(t);
		b.obst.width       = coord15(w);
		b.obst.height      = coord15(h);
		b.obst.see_through = clear_mark;
		send_beat(b);
	endtask

	task automatic query_at(input int x, input int y);
		layout_beat_t b;
		b = random_beat(MODE_QUERY);
		b.start_left = coord15(x);
		b.start_top  = coord15(y);
		send_beat(b);
	endtask

	function automatic layout_regs_t pick_layout(input layout_kind_t kind);
		layout_regs_t regs;
		case (kind)
			LAYOUT_TYPICAL: begin
				regs[REG_PAGE_WIDTH]    = $urandom_range(600, 6000);
				regs[REG_LEFT_MARGIN]   = $urandom_range(0, 300);
				regs[REG_RIGHT_MARGIN]  = $urandom_range(0, 300);
				regs[REG_NUM_COLUMNS]   = $urandom_range(1, 4);
				regs[REG_COLUMN_GUTTER] = $urandom_range(0, 120);
				regs[REG_PAGE_HEIGHT]   = $urandom_range(800, 8000);
				regs[REG_BOTTOM_MARGIN] = $urandom_range(0, 300);
			end
			LAYOUT_WILD: begin
				foreach (regs[r])
					regs[r] = $urandom_range(0, 32767);
				regs[REG_NUM_COLUMNS] = $urandom_range(0, 31);
			end
			LAYOUT_ZERO: begin
				// Zero columns goes in here as well.
				foreach (regs[r])
					regs[r] = 0;
			end
			default: begin
				foreach (regs[r])
					regs[r] = 32767;
				regs[REG_NUM_COLUMNS] = 16;
			end
		endcase
		return regs;
	endfunction

	// One page's worth of work: usually a clear, a batch of obstacles placed on
	// the current page, then queries at column starts and at rows that some of
	// those obstacles cover, so that both narrowing and capping get exercised.
	task automatic fill_page(input bit fresh, input int n_obst, input int n_query);
		layout_beat_t b;
		int           tops [$];
		int           heights [$];
		int           ncol, pitch, pick;
		if (fresh)
			send_beat(random_beat(MODE_CLEAR));
		for (int i = 0; i < n_obst; i++) begin
			b = random_beat(MODE_APPEND);
			if ($urandom_range(0, 9) != 0) begin
				b.obst.left        = coord15($urandom_range(0, lay_page_w));
				b.obst.top         = coord15($urandom_range(0, lay_page_h));
				b.obst.width       = coord15($urandom_range(8, lay_page_w / 3 + 8));
				b.obst.height      = coord15($urandom_range(8, lay_page_h / 5 + 8));
				b.obst.see_through = ($urandom_range(0, 4) == 0);
			end
			tops.push_back(int'(b.obst.top));
			heights.push_back(int'(b.obst.height));
			send_beat(b);
		end
		ncol = (lay_cols == '0) ? 1 : int'(lay_cols);
		pitch = (int'(lay_page_w) - int'(lay_right_m) - int'(lay_left_m)
		        - (ncol - 1) * int'(lay_gutter)) / ncol + int'(lay_gutter);
		if (pitch < 0)
			pitch = 0;
		for (int q = 0; q < n_query; q++) begin
			b = random_beat(MODE_QUERY);
			if ($urandom_range(0, 4) != 0)
				b.start_left = coord15(int'(lay_left_m) + $urandom_range(0, ncol - 1) * pitch);
			if (tops.size() != 0 && $urandom_range(0, 1) == 1) begin
				pick = $urandom_range(0, tops.size() - 1);
				b.start_top = coord15(tops[pick] + $urandom_range(0, heights[pick]));
			end else if ($urandom_range(0, 4) != 0) begin
				b.start_top = coord15($urandom_range(0, lay_page_h));
			end
			send_beat(b);
		end
	endtask

	// Mostly well-formed pages, now and then one that overfills the table, and
	// a sprinkling of stray beats of any mode with arbitrary fields.
	task automatic random_pages(input int budget);
		int first;
		first = beats_sent;
		while (beats_sent - first < budget) begin
			if ($urandom_range(0, 9) == 0)
				send_beat(random_beat($urandom_range(MODE_CLEAR, MODE_UNUSED)));
			else if ($urandom_range(0, 14) == 0)
				fill_page($urandom_range(0, 3) != 0, $urandom_range(60, 70),
				          $urandom_range(1, 3));
			else
				fill_page($urandom_range(0, 3) != 0, $urandom_range(0, 10),
				          $urandom_range(1, 8));
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Queries against the reset geometry and an empty table, plus an unused
	// mode beat with every field at its top value.
	task automatic test_reset_state();
		layout_beat_t b;
		query_at(0, 0);
		b = '1;
		b.mode = MODE_UNUSED;
		send_beat(b);
		query_at(32767, 32767);
	endtask

	// A two-column page with hand-placed obstacles: one that narrows from the
	// right, a see-through one that must be ignored, one below that caps the
	// height, one on the left that pushes the span over, one that leaves the
	// span too narrow, a start just above an obstacle so the height is too
	// small, a start far below the page, and the field extremes.
	task automatic test_directed_layout();
		layout_regs_t regs;
		settle();
		regs[REG_PAGE_WIDTH]    = 1240;
		regs[REG_LEFT_MARGIN]   = 100;
		regs[REG_RIGHT_MARGIN]  = 100;
		regs[REG_NUM_COLUMNS]   = 2;
		regs[REG_COLUMN_GUTTER] = 40;
		regs[REG_PAGE_HEIGHT]   = 1754;
		regs[REG_BOTTOM_MARGIN] = 100;
		load_layout(regs);
		send_beat(random_beat(MODE_CLEAR));
		append_obst(400, 300, 200, 200, 1'b0);
		append_obst(0, 0, 2000, 2000, 1'b1);
		append_obst(150, 900, 100, 50, 1'b0);
		append_obst(0, 1000, 150, 100, 1'b0);
		append_obst(650, 1000, 300, 50, 1'b0);
		query_at(100, 350);
		query_at(100, 600);
		query_at(100, 1020);
		query_at(640, 1020);
		query_at(100, 880);
		query_at(100, 32767);
		append_obst(32767, 32767, 32767, 32767, 1'b0);
		append_obst(0, 0, 0, 0, 1'b0);
		query_at(0, 0);
		query_at(32767, 32767);
		send_beat(random_beat(MODE_CLEAR));
		query_at(100, 350);
	endtask

	// Geometry extremes: everything zero (zero columns), everything but the
	// column count (sixteen) at the top of its range, and a column count past that.
	task automatic test_column_extremes();
		layout_regs_t regs;
		settle();
		load_layout(pick_layout(LAYOUT_ZERO));
		send_beat(random_beat(MODE_CLEAR));
		append_obst(0, 0, 500, 500, 1'b0);
		query_at(0, 0);
		query_at(32767, 0);
		settle();
		load_layout(pick_layout(LAYOUT_MAX));
		query_at(0, 0);
		query_at(200, 100);
		settle();
		regs = pick_layout(LAYOUT_TYPICAL);
		regs[REG_NUM_COLUMNS] = 31;
		load_layout(regs);
		query_at(int'(lay_left_m), 10);
	endtask

	// Fill the table past its capacity; the extra appends must be dropped.
	task automatic test_table_full();
		settle();
		load_layout(pick_layout(LAYOUT_TYPICAL));
		fill_page(1'b1, MAX_OBST + 6, 4);
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering queries back to back, so the result register fills, the next
	// query parks behind it and the block finally stalls its input.
	task automatic test_output_backpressure();
		in_idle_on = 1'b0;
		send_beat(random_beat(MODE_CLEAR));
		append_obst(int'(lay_left_m) + 200, 100, 150, 300, 1'b0);
		append_obst(int'(lay_left_m), 600, 400, 60, 1'b0);
		append_obst(0, 0, 100, 100, 1'b1);
		hold_off_len = HOLD_OFF_CYCLES;
		for (int q = 0; q < 8; q++)
			query_at(int'(lay_left_m), $urandom_range(0, 900));
		in_idle_on = 1'b1;
	endtask

	// Several geometry settings, each followed by a run of random pages.
	task automatic test_random_layouts();
		layout_kind_t kinds [5];
		kinds = '{LAYOUT_TYPICAL, LAYOUT_WILD, LAYOUT_TYPICAL, LAYOUT_TYPICAL,
		          LAYOUT_TYPICAL};
		foreach (kinds[k]) begin
			settle();
			load_layout(pick_layout(kinds[k]));
			random_pages(120);
		end
	endtask

	// Closing stretch with no idling on either side, so that back-to-back
	// beats in both directions are covered too.
	task automatic test_quiet_tail();
		settle();
		load_layout(pick_layout(LAYOUT_TYPICAL));
		in_idle_on = 1'b0;
		out_idle_on = 1'b0;
		random_pages(60);
	endtask

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	function automatic void check_field(input string name, input longint unsigned want_v,
	                                    input longint unsigned got_v);
		if (want_v != got_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
			fail_count++;
		end
	endfunction

	// Each result beat taken at a clock edge is matched against the oldest
	// owed answer.
	initial begin : result_checker
		free_rect_t want;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (expected_rects.size() == 0) begin
					$error("result beat with no query outstanding (found %0d)", found);
					fail_count++;
				end else begin
					want = expected_rects.pop_front();
					check_field("found", want.found, found);
					check_field("rect_left", want.left, rect_left);
					check_field("rect_top", want.top, rect_top);
					check_field("rect_width", want.width, rect_width);
					check_field("rect_height", want.height, rect_height);
					check_field("blocked", want.blocked, blocked);
				end
			end
		end
	end

	// Receiver side: alternates random stall bursts with free-running
	// stretches, and serves a long hold-off when a test asks for one.
	initial begin : result_receiver
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_len != 0) begin
				out_stall <= 1'b1;
				repeat (hold_off_len) @(posedge clk);
				hold_off_len = 0;
				out_stall <= 1'b0;
			end else if (out_idle_on && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(0, 15)) @(posedge clk);
			end
		end
	end

	// Hang detector: any beat on any channel restarts the count.
	initial begin : watchdog
		int idle_streak;
		idle_streak = 0;
		while (idle_streak < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			    (cfg_valid && cfg_ready))
				idle_streak = 0;
			else
				idle_streak++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n          <= 1'b0;
		in_valid        <= 1'b0;
		mode            <= MODE_CLEAR;
		obstacle_left   <= '0;
		obstacle_top    <= '0;
		obstacle_width  <= '0;
		obstacle_height <= '0;
		see_through     <= 1'b0;
		start_left      <= '0;
		start_top       <= '0;
		cfg_valid       <= 1'b0;
		cfg_index       <= REG_PAGE_WIDTH;
		cfg_data        <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_directed_layout();
		test_column_extremes();
		test_table_full();
		test_output_backpressure();
		test_random_layouts();
		test_quiet_tail();

		// Everything sent: wait out the owed answers, then a little longer so
		// that a stray extra beat would still be caught.
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_rects.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
